/* design/sca_pkg.sv */
// Shared constants, codes and types for the sound channel allocator.
package sca_pkg;

    // Channel table size and field widths.
    localparam int MaxChannels = 32;
    localparam int ChanW       = 5;
    localparam int CntW        = $clog2(MaxChannels + 1);
    localparam int CfgW        = 6;
    localparam int SrcW        = 16;
    localparam int ClsW        = 3;
    localparam int PriW        = 8;
    localparam int OpW         = 2;
    localparam int StatW       = 3;

    // Channel count after reset.
    localparam logic [CfgW-1:0] CountReset = CfgW'(8);

    // Request operations.
    typedef enum logic [OpW-1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_FREE  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    // Result status codes.
    typedef enum logic [StatW-1:0] {
        ST_GRANTED  = 3'd0,
        ST_REPLACED = 3'd1,
        ST_EVICTED  = 3'd2,
        ST_REJECTED = 3'd3,
        ST_STOPPED  = 3'd4,
        ST_NONE     = 3'd5,
        ST_CLEARED  = 3'd6
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    // Owner record stored per channel.
    typedef struct packed {
        logic [SrcW-1:0] src;
        logic [ClsW-1:0] cls;
        logic [PriW-1:0] prio;
    } owner_t;

    // Access request from the sequencer to the owner memory.
    typedef struct packed {
        logic             rd_en;
        logic [ChanW-1:0] rd_addr;
        logic             wr_en;
        logic [ChanW-1:0] wr_addr;
        owner_t           wr_data;
    } mem_req_t;

endpackage

/* design/sound_channel_allocator.sv */
// Sound channel allocator top level: configuration register, sequencer and owner memory.
// A start or stop scans the owner memory for the N channels in use, N = channels in use,
// through its single read port; free and clear skip the scan and go straight to the result.
// Throughput: one item at a time, the next transfer is taken once the result is registered.
// Reset clears all busy flags and sets channels in use to 8; owner records need no clearing.
module sound_channel_allocator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [sca_pkg::CfgW-1:0]   cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [sca_pkg::OpW-1:0]    op,
    input  logic [sca_pkg::SrcW-1:0]   source_id,
    input  logic [sca_pkg::ClsW-1:0]   sound_class,
    input  logic [sca_pkg::PriW-1:0]   priority_req,
    input  logic [sca_pkg::ChanW-1:0]  channel,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [sca_pkg::StatW-1:0]  status,
    output logic [sca_pkg::ChanW-1:0]  granted_channel,
    output logic                       stop_valid,
    output logic [sca_pkg::ChanW-1:0]  stopped_channel
);

    logic [sca_pkg::CfgW-1:0] cfg_count_reg;
    logic [sca_pkg::CntW-1:0] chan_count;
    sca_pkg::mem_req_t        mem_req;
    sca_pkg::owner_t          mem_rd_data;

    // Channel count register, written on every configuration transfer.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_count_reg <= sca_pkg::CountReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cfg_count_reg <= cfg_data;
        end
    end

    // Limit the usable channels to the table size.
    always_comb
    begin
        if (int'(cfg_count_reg) > sca_pkg::MaxChannels)
        begin
            chan_count = sca_pkg::CntW'(sca_pkg::MaxChannels);
        end
        else
        begin
            chan_count = sca_pkg::CntW'(cfg_count_reg);
        end
    end

    sca_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .chan_count      (chan_count),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .source_id       (source_id),
        .sound_class     (sound_class),
        .priority_req    (priority_req),
        .channel         (channel),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .granted_channel (granted_channel),
        .stop_valid      (stop_valid),
        .stopped_channel (stopped_channel),
        .mem_req         (mem_req),
        .mem_rd_data     (mem_rd_data)
    );

    sca_owner_mem u_owner_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    // An accepted item keeps the input side stalled in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after a transfer");

    // An eviction silences exactly the channel it hands out.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == sca_pkg::ST_EVICTED))
        |-> (stop_valid && (stopped_channel == granted_channel)))
        else $error("eviction reports a different stopped channel");

    // A rejected start grants nothing and silences nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == sca_pkg::ST_REJECTED))
        |-> (!stop_valid && (granted_channel == '0)))
        else $error("rejected start carries a channel");

    // Nothing stopped and clear all never flag a single channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((status == sca_pkg::ST_NONE) || (status == sca_pkg::ST_CLEARED)))
        |-> (!stop_valid && (stopped_channel == '0)))
        else $error("stop flagged without a stopped channel");

endmodule

/* design/sca_owner_mem.sv */
// Owner record memory: one write port, one read port, registered read data.
module sca_owner_mem (
    input  logic              clk,
    input  sca_pkg::mem_req_t req,
    output sca_pkg::owner_t   rd_data
);

    sca_pkg::owner_t owner_mem [sca_pkg::MaxChannels];
    sca_pkg::owner_t rd_data_reg;

    // Synchronous write and synchronous read into a read data register.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            owner_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= owner_mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/sca_ctrl.sv */
// Request sequencer: busy flags, table scan, result decision and output register.
module sca_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [sca_pkg::CntW-1:0]   chan_count,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [sca_pkg::OpW-1:0]    op,
    input  logic [sca_pkg::SrcW-1:0]   source_id,
    input  logic [sca_pkg::ClsW-1:0]   sound_class,
    input  logic [sca_pkg::PriW-1:0]   priority_req,
    input  logic [sca_pkg::ChanW-1:0]  channel,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [sca_pkg::StatW-1:0]  status,
    output logic [sca_pkg::ChanW-1:0]  granted_channel,
    output logic                       stop_valid,
    output logic [sca_pkg::ChanW-1:0]  stopped_channel,
    output sca_pkg::mem_req_t          mem_req,
    input  sca_pkg::owner_t            mem_rd_data
);

    sca_pkg::state_t state_reg;
    sca_pkg::state_t state_next;

    // Latched request.
    sca_pkg::op_t                op_reg;
    logic [sca_pkg::SrcW-1:0]    src_reg;
    logic [sca_pkg::ClsW-1:0]    cls_reg;
    logic [sca_pkg::PriW-1:0]    pri_reg;
    logic [sca_pkg::ChanW-1:0]   chan_reg;
    logic [sca_pkg::CntW-1:0]    n_reg;

    // Scan pipeline and trackers.
    logic [sca_pkg::CntW-1:0]    idx_reg;
    logic                        chk_valid_reg;
    logic [sca_pkg::ChanW-1:0]   chk_idx_reg;
    logic                        match_found_reg;
    logic [sca_pkg::ChanW-1:0]   match_idx_reg;
    logic                        free_found_reg;
    logic [sca_pkg::ChanW-1:0]   free_idx_reg;
    logic                        prio_found_reg;
    logic [sca_pkg::ChanW-1:0]   prio_idx_reg;

    logic [sca_pkg::MaxChannels-1:0] busy_reg;
    logic [sca_pkg::MaxChannels-1:0] busy_next;

    // Output register.
    logic                        out_valid_reg;
    sca_pkg::status_t            status_reg;
    logic [sca_pkg::ChanW-1:0]   granted_reg;
    logic                        stop_reg;
    logic [sca_pkg::ChanW-1:0]   stopped_reg;

    logic                        accept;
    logic                        issue;
    logic                        out_load;
    logic                        chk_busy;
    logic                        chk_match;
    logic                        chk_free;
    logic                        chk_evict;

    sca_pkg::status_t            res_status;
    logic [sca_pkg::ChanW-1:0]   res_granted;
    logic                        res_stop;
    logic [sca_pkg::ChanW-1:0]   res_stopped;
    logic                        grant_en;
    logic                        clr_en;
    logic                        clear_all;

    // Sequencer next state and handshake strobes.
    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        issue      = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            sca_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if ((sca_pkg::op_t'(op) inside {sca_pkg::OP_START, sca_pkg::OP_STOP})
                        && (chan_count != '0))
                    begin
                        state_next = sca_pkg::S_SCAN;
                    end
                    else
                    begin
                        state_next = sca_pkg::S_DONE;
                    end
                end
            end
            sca_pkg::S_SCAN:
            begin
                issue = (idx_reg < n_reg);
                if (!issue && !chk_valid_reg)
                begin
                    state_next = sca_pkg::S_DONE;
                end
            end
            sca_pkg::S_DONE:
            begin
                out_load = !out_valid_reg || !out_stall;
                if (out_load)
                begin
                    state_next = sca_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sca_pkg::S_IDLE;
            end
        endcase
    end

    assign accept = in_valid && !in_stall;

    // Per-entry tests on the record returned by the memory.
    assign chk_busy  = busy_reg[chk_idx_reg];
    assign chk_match = chk_valid_reg && chk_busy && (mem_rd_data.src == src_reg)
                       && ((op_reg == sca_pkg::OP_STOP) || (mem_rd_data.cls == cls_reg));
    assign chk_free  = chk_valid_reg && !chk_busy;
    assign chk_evict = chk_valid_reg && chk_busy && (mem_rd_data.prio >= pri_reg);

    // Result of the finished scan.
    always_comb
    begin
        res_status  = sca_pkg::ST_NONE;
        res_granted = '0;
        res_stop    = 1'b0;
        res_stopped = '0;
        grant_en    = 1'b0;
        clr_en      = 1'b0;
        clear_all   = 1'b0;
        case (op_reg)
            sca_pkg::OP_START:
            begin
                if (match_found_reg)
                begin
                    // The freed channel counts as free for the new sound.
                    res_status  = sca_pkg::ST_REPLACED;
                    res_stop    = 1'b1;
                    res_stopped = match_idx_reg;
                    clr_en      = 1'b1;
                    grant_en    = 1'b1;
                    res_granted = (free_found_reg && (free_idx_reg < match_idx_reg))
                                  ? free_idx_reg : match_idx_reg;
                end
                else if (free_found_reg)
                begin
                    res_status  = sca_pkg::ST_GRANTED;
                    res_granted = free_idx_reg;
                    grant_en    = 1'b1;
                end
                else if (prio_found_reg)
                begin
                    res_status  = sca_pkg::ST_EVICTED;
                    res_granted = prio_idx_reg;
                    res_stop    = 1'b1;
                    res_stopped = prio_idx_reg;
                    grant_en    = 1'b1;
                end
                else
                begin
                    res_status = sca_pkg::ST_REJECTED;
                end
            end
            sca_pkg::OP_STOP:
            begin
                if (match_found_reg)
                begin
                    res_status  = sca_pkg::ST_STOPPED;
                    res_stop    = 1'b1;
                    res_stopped = match_idx_reg;
                    clr_en      = 1'b1;
                end
            end
            sca_pkg::OP_FREE:
            begin
                if ((sca_pkg::CntW'(chan_reg) < n_reg) && busy_reg[chan_reg])
                begin
                    res_status  = sca_pkg::ST_STOPPED;
                    res_stop    = 1'b1;
                    res_stopped = chan_reg;
                    clr_en      = 1'b1;
                end
            end
            sca_pkg::OP_CLEAR:
            begin
                res_status = sca_pkg::ST_CLEARED;
                clear_all  = 1'b1;
            end
            default:
            begin
                res_status = sca_pkg::ST_NONE;
            end
        endcase
    end

    // Busy flag update applied when the result is registered.
    always_comb
    begin
        busy_next = busy_reg;
        if (clear_all)
        begin
            busy_next = '0;
        end
        else
        begin
            if (clr_en)
            begin
                busy_next[res_stopped] = 1'b0;
            end
            if (grant_en)
            begin
                busy_next[res_granted] = 1'b1;
            end
        end
    end

    // Memory reads walk the table; the owner record is written with the grant.
    always_comb
    begin
        mem_req.rd_en   = issue;
        mem_req.rd_addr = idx_reg[sca_pkg::ChanW-1:0];
        mem_req.wr_en   = out_load && grant_en;
        mem_req.wr_addr = res_granted;
        mem_req.wr_data = '{src: src_reg, cls: cls_reg, prio: pri_reg};
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= sca_pkg::S_IDLE;
            busy_reg        <= '0;
            out_valid_reg   <= 1'b0;
            chk_valid_reg   <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            prio_found_reg  <= 1'b0;
            idx_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= issue;
            if (out_load)
            begin
                busy_reg      <= busy_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                idx_reg         <= '0;
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
                prio_found_reg  <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (chk_match)
                begin
                    match_found_reg <= 1'b1;
                end
                if (chk_free)
                begin
                    free_found_reg <= 1'b1;
                end
                if (chk_evict)
                begin
                    prio_found_reg <= 1'b1;
                end
            end
        end
    end

    // Request, tracker index and result payload registers.
    always_ff @(posedge clk)
    begin
        chk_idx_reg <= idx_reg[sca_pkg::ChanW-1:0];
        if (accept)
        begin
            op_reg   <= sca_pkg::op_t'(op);
            src_reg  <= source_id;
            cls_reg  <= sound_class;
            pri_reg  <= priority_req;
            chan_reg <= channel;
            n_reg    <= chan_count;
        end
        if (chk_match && !match_found_reg)
        begin
            match_idx_reg <= chk_idx_reg;
        end
        if (chk_free && !free_found_reg)
        begin
            free_idx_reg <= chk_idx_reg;
        end
        if (chk_evict && !prio_found_reg)
        begin
            prio_idx_reg <= chk_idx_reg;
        end
        if (out_load)
        begin
            status_reg  <= res_status;
            granted_reg <= res_granted;
            stop_reg    <= res_stop;
            stopped_reg <= res_stopped;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign granted_channel = granted_reg;
    assign stop_valid      = stop_reg;
    assign stopped_channel = stopped_reg;

endmodule

/* tb/sv/sound_channel_allocator_tb.sv */
// Self-checking testbench for the sound channel allocator with a built-in channel table predictor.
`timescale 1ns / 100ps

module sound_channel_allocator_tb;
    import sca_pkg::*;

    localparam int CycleLimit = 600000;
    localparam int IdlePct    = 23;

    // One request as the sender queues it; hold makes the sender wait for a drained block.
    typedef struct packed {
        op_t              op;
        logic [SrcW-1:0]  src;
        logic [ClsW-1:0]  cls;
        logic [PriW-1:0]  pri;
        logic [ChanW-1:0] chan;
        logic             hold;
    } alloc_req_t;

    // One allocation outcome.
    typedef struct packed {
        status_t          status;
        logic [ChanW-1:0] granted;
        logic             stop;
        logic [ChanW-1:0] stopped;
    } alloc_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CfgW-1:0]  cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [OpW-1:0]   op = '0;
    logic [SrcW-1:0]  source_id = '0;
    logic [ClsW-1:0]  sound_class = '0;
    logic [PriW-1:0]  priority_req = '0;
    logic [ChanW-1:0] channel = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [StatW-1:0] status;
    logic [ChanW-1:0] granted_channel;
    logic             stop_valid;
    logic [ChanW-1:0] stopped_channel;

    // Predicted channel table and register copy.
    logic             busy_map [MaxChannels];
    logic [SrcW-1:0]  src_tab  [MaxChannels];
    logic [ClsW-1:0]  cls_tab  [MaxChannels];
    logic [PriW-1:0]  pri_tab  [MaxChannels];
    logic [CfgW-1:0]  chan_limit;

    alloc_req_t    request_q [$];
    alloc_result_t outcome_q [$];

    int  mismatches = 0;
    int  transfers_in = 0;
    int  outcomes_seen = 0;
    int  cfg_writes = 0;
    int  cycle_count = 0;
    int  status_hits [8];
    bit  steady = 1'b0;

    sound_channel_allocator u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .source_id       (source_id),
        .sound_class     (sound_class),
        .priority_req    (priority_req),
        .channel         (channel),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .granted_channel (granted_channel),
        .stop_valid      (stop_valid),
        .stopped_channel (stopped_channel)
    );

    // 12 ns clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Apply one request to the predicted table and return the outcome.
    function automatic alloc_result_t allocate(input alloc_req_t rq);
        alloc_result_t res;
        int n;
        int i;
        bit replaced;
        bit found;
        res = '{status: ST_NONE, granted: '0, stop: 1'b0, stopped: '0};
        n = (chan_limit > MaxChannels) ? MaxChannels : int'(chan_limit);
        replaced = 1'b0;
        found = 1'b0;
        case (rq.op)
            OP_START:
            begin
                // Drop the sound that this source already plays in the same class.
                for (i = 0; i < n; i++)
                begin
                    if (busy_map[i] && src_tab[i] == rq.src && cls_tab[i] == rq.cls)
                    begin
                        busy_map[i] = 1'b0;
                        replaced = 1'b1;
                        res.stop = 1'b1;
                        res.stopped = ChanW'(i);
                        break;
                    end
                end
                // Lowest free channel.
                for (i = 0; i < n; i++)
                begin
                    if (!busy_map[i])
                    begin
                        found = 1'b1;
                        res.granted = ChanW'(i);
                        res.status = replaced ? ST_REPLACED : ST_GRANTED;
                        break;
                    end
                end
                // Table full: evict the first sound that does not outrank the new one.
                if (!found)
                begin
                    for (i = 0; i < n; i++)
                    begin
                        if (pri_tab[i] >= rq.pri)
                        begin
                            found = 1'b1;
                            res.granted = ChanW'(i);
                            res.status = ST_EVICTED;
                            res.stop = 1'b1;
                            res.stopped = ChanW'(i);
                            break;
                        end
                    end
                end
                if (found)
                begin
                    busy_map[res.granted] = 1'b1;
                    src_tab[res.granted] = rq.src;
                    cls_tab[res.granted] = rq.cls;
                    pri_tab[res.granted] = rq.pri;
                end
                else
                begin
                    res.status = ST_REJECTED;
                    res.granted = '0;
                end
            end
            OP_STOP:
            begin
                for (i = 0; i < n; i++)
                begin
                    if (busy_map[i] && src_tab[i] == rq.src)
                    begin
                        busy_map[i] = 1'b0;
                        res.status = ST_STOPPED;
                        res.stop = 1'b1;
                        res.stopped = ChanW'(i);
                        break;
                    end
                end
            end
            OP_FREE:
            begin
                if (int'(rq.chan) < n && busy_map[rq.chan])
                begin
                    busy_map[rq.chan] = 1'b0;
                    res.status = ST_STOPPED;
                    res.stop = 1'b1;
                    res.stopped = rq.chan;
                end
            end
            default:
            begin
                for (i = 0; i < MaxChannels; i++)
                    busy_map[i] = 1'b0;
                res.status = ST_CLEARED;
            end
        endcase
        return res;
    endfunction

    function automatic alloc_req_t make_req(input op_t code, input int src, input int cls,
                                            input int pri, input int chan);
        alloc_req_t rq;
        rq.op = code;
        rq.src = SrcW'(src);
        rq.cls = ClsW'(cls);
        rq.pri = PriW'(pri);
        rq.chan = ChanW'(chan);
        rq.hold = 1'b0;
        return rq;
    endfunction

    // Random request: a small pool of sources and classes so that matches, refills and
    // evictions happen often, with full-range values mixed in.
    function automatic alloc_req_t pick_req(input int start_pct, input int lim);
        alloc_req_t rq;
        int roll;
        int src;
        int cls;
        int chan;
        roll = $urandom_range(99);
        src = ($urandom_range(9) < 7) ? $urandom_range(5) : $urandom;
        cls = ($urandom_range(3) != 0) ? $urandom_range(2) : $urandom_range(7);
        if (lim > 0 && $urandom_range(9) < 7)
            chan = $urandom_range((lim > MaxChannels ? MaxChannels : lim) - 1);
        else
            chan = $urandom_range(31);
        if (roll < start_pct)
            rq = make_req(OP_START, src, cls, $urandom_range(255), chan);
        else if (roll < start_pct + (97 - start_pct) / 2)
            rq = make_req(OP_STOP, src, cls, $urandom_range(255), chan);
        else if (roll < 97)
            rq = make_req(OP_FREE, src, cls, $urandom_range(255), chan);
        else
            rq = make_req(OP_CLEAR, src, cls, $urandom_range(255), chan);
        rq.hold = ($urandom_range(49) == 0);
        return rq;
    endfunction

    // Request driver: predicts each transfer and launches the next queued request.
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        alloc_req_t cur;
        alloc_req_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                cur = make_req(op_t'(op), source_id, sound_class, priority_req, channel);
                outcome_q.push_back(allocate(cur));
                transfers_in++;
            end
            if (!in_valid || !in_stall)
            begin
                if (request_q.size() > 0
                    && !(request_q[0].hold && outcome_q.size() > 0)
                    && (steady || $urandom_range(99) >= IdlePct))
                begin
                    nxt = request_q.pop_front();
                    in_valid <= 1'b1;
                    op <= nxt.op;
                    source_id <= nxt.src;
                    sound_class <= nxt.cls;
                    priority_req <= nxt.pri;
                    channel <= nxt.chan;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Result monitor: compares each transfer with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        alloc_result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (outcome_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $time, status);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    check_field("status", want.status, status);
                    check_field("granted_channel", want.granted, granted_channel);
                    check_field("stop_valid", want.stop, stop_valid);
                    check_field("stopped_channel", want.stopped, stopped_channel);
                    outcomes_seen++;
                    status_hits[status]++;
                end
            end
            out_stall <= !steady && ($urandom_range(99) < IdlePct);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("watchdog expired after %0d cycles, %0d results pending",
                     cycle_count, outcome_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Wait until the block has nothing in flight, plus a short settling gap.
    task automatic wait_drained();
        while (request_q.size() > 0 || outcome_q.size() > 0 || in_valid)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_channel_count(input int value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= CfgW'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        chan_limit = CfgW'(value);
        cfg_writes++;
    endtask

    // One phase: drain, set the channel count, then queue random requests.
    task automatic run_phase(input int count_cfg, input int items, input int start_pct,
                             input bit calm);
        int k;
        wait_drained();
        write_channel_count(count_cfg);
        steady = calm;
        for (k = 0; k < items; k++)
            request_q.push_back(pick_req(start_pct, count_cfg));
    endtask

    initial
    begin : stimulus
        int k;
        for (k = 0; k < MaxChannels; k++)
        begin
            busy_map[k] = 1'b0;
            src_tab[k] = '0;
            cls_tab[k] = '0;
            pri_tab[k] = '0;
        end
        chan_limit = CountReset;
        for (k = 0; k < 8; k++)
            status_hits[k] = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests at the reset channel count of eight.
        request_q.push_back(make_req(OP_CLEAR, 0, 0, 0, 0));
        request_q.push_back(make_req(OP_START, 0, 0, 0, 0));
        // Same global source and class again: replaced in place.
        request_q.push_back(make_req(OP_START, 0, 0, 10, 0));
        request_q.push_back(make_req(OP_START, 16'hFFFF, 7, 255, 31));
        request_q.push_back(make_req(OP_FREE, 0, 0, 0, 0));
        // Replacement whose new channel lies below the one it frees.
        request_q.push_back(make_req(OP_START, 16'hFFFF, 7, 255, 0));
        for (k = 1; k <= 7; k++)
            request_q.push_back(make_req(OP_START, k, 1, 100, 0));
        // Table full: evict, reject, evict again.
        request_q.push_back(make_req(OP_START, 20, 2, 254, 0));
        request_q.push_back(make_req(OP_START, 21, 2, 255, 0));
        request_q.push_back(make_req(OP_START, 22, 2, 100, 0));
        request_q.push_back(make_req(OP_STOP, 3, 0, 0, 0));
        request_q.push_back(make_req(OP_STOP, 999, 0, 0, 0));
        // Free above the limit and free of an idle channel.
        request_q.push_back(make_req(OP_FREE, 0, 0, 0, 31));
        request_q.push_back(make_req(OP_FREE, 0, 0, 0, 3));
        request_q.push_back(make_req(OP_FREE, 0, 0, 0, 4));
        request_q.push_back(make_req(OP_CLEAR, 16'hFFFF, 7, 255, 31));
        request_q.push_back(make_req(OP_FREE, 0, 0, 0, 7));
        request_q[request_q.size() - 1].hold = 1'b1;

        // Random phases over a spread of channel counts.
        run_phase(1, 120, 60, 1'b0);
        run_phase(63, 250, 85, 1'b0);
        run_phase(0, 20, 50, 1'b0);
        run_phase(4, 200, 60, 1'b0);
        run_phase(32, 200, 80, 1'b1);
        run_phase($urandom_range(1, 32), 120, 65, 1'b0);
        run_phase($urandom_range(1, 32), 120, 65, 1'b0);
        steady = 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);

        $display("covered %0d transfers, %0d results, %0d channel count writes",
                 transfers_in, outcomes_seen, cfg_writes);
        $display("granted %0d replaced %0d evicted %0d rejected %0d stopped %0d none %0d cleared %0d",
                 status_hits[ST_GRANTED], status_hits[ST_REPLACED], status_hits[ST_EVICTED],
                 status_hits[ST_REJECTED], status_hits[ST_STOPPED], status_hits[ST_NONE],
                 status_hits[ST_CLEARED]);
        if (mismatches == 0 && outcome_q.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
